// File: rtl/gpf_pkg.sv
// Shared constants and types of the Goldbach prime pair finder.
package gpf_pkg;

  localparam int WordW = 32;   // map word: 32 odd numbers per word
  localparam int NumW  = 22;   // sieve counters, room for limit plus one stride
  localparam int LimW  = 21;   // sieve limit register
  localparam int QryW  = 20;   // query and result numbers

  localparam logic [LimW-1:0] LimitMin   = LimW'(8);
  localparam int              LimitReset = 1000000;

  // register index taken from paddr[2]
  localparam logic RegSieveLimit = 1'b0;

  localparam logic StatusPair   = 1'b0;
  localparam logic StatusReject = 1'b1;

  typedef struct packed {
    logic sieve_ready;  // map holds the sieve for the current limit
    logic res_take;     // output register can load a result this cycle
  } seq_ctl_t;

  typedef struct packed {
    logic res_load;     // result loaded into output register
    logic built;        // sieve build finished
  } seq_stat_t;

endpackage

// File: rtl/gpf_map.sv
// Composite map of odd numbers: one write port, two registered read ports.
module gpf_map import gpf_pkg::*; #(
  parameter int Words = 16384,
  parameter int AddrW = 14
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WordW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [WordW-1:0] rdata_a_o,
  output logic [WordW-1:0] rdata_b_o
);

  logic [WordW-1:0] mem_q [Words];
  logic [WordW-1:0] rdata_a_q;
  logic [WordW-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// File: rtl/gpf_seq.sv
// Sequencer: clears and sieves the map when it is stale, then walks candidate pairs of a query.
module gpf_seq import gpf_pkg::*; #(
  parameter int AddrW = 14
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [LimW-1:0]  limit_i,
  input  seq_ctl_t         ctl_i,
  output seq_stat_t        stat_o,
  input  logic             q_valid_i,
  output logic             q_stall_o,
  input  logic [QryW-1:0]  q_number_i,
  output logic [QryW-1:0]  res_small_o,
  output logic [QryW-1:0]  res_large_o,
  output logic             res_status_o,
  output logic             mem_we_o,
  output logic [AddrW-1:0] mem_waddr_o,
  output logic [WordW-1:0] mem_wdata_o,
  output logic [AddrW-1:0] mem_raddr_a_o,
  output logic [AddrW-1:0] mem_raddr_b_o,
  input  logic [WordW-1:0] mem_rdata_a_i,
  input  logic [WordW-1:0] mem_rdata_b_i
);

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SClr    = 4'd1;
  localparam logic [3:0] SSvTest = 4'd2;
  localparam logic [3:0] SSvChk  = 4'd3;
  localparam logic [3:0] SMkRd   = 4'd4;
  localparam logic [3:0] SMkWr   = 4'd5;
  localparam logic [3:0] SQSet   = 4'd6;
  localparam logic [3:0] SQRd    = 4'd7;
  localparam logic [3:0] SQChk   = 4'd8;
  localparam logic [3:0] SDone   = 4'd9;

  logic [3:0]       state_q, state_d;
  logic [QryW-1:0]  n_q, n_d;
  logic [QryW-1:0]  p_q, p_d;
  logic [QryW-1:0]  m_q, m_d;
  logic [NumW-1:0]  i_q, i_d;
  logic [NumW-1:0]  sq_q, sq_d;
  logic [NumW-1:0]  j_q, j_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [QryW-1:0]  small_q, small_d;
  logic [QryW-1:0]  large_q, large_d;
  logic             status_q, status_d;

  logic [NumW-1:0]  lim_ext;
  logic [LimW-1:0]  lim_m1;
  logic [AddrW-1:0] last_word;

  function automatic logic [AddrW-1:0] word_of(input logic [NumW-1:0] k);
    logic [NumW-1:0] t;
    t = k >> 6;
    return t[AddrW-1:0];
  endfunction

  assign lim_ext   = NumW'(limit_i);
  assign lim_m1    = limit_i - LimW'(1);
  assign last_word = word_of(NumW'(lim_m1));

  always_comb begin
    state_d       = state_q;
    n_d           = n_q;
    p_d           = p_q;
    m_d           = m_q;
    i_d           = i_q;
    sq_d          = sq_q;
    j_d           = j_q;
    clr_d         = clr_q;
    small_d       = small_q;
    large_d       = large_q;
    status_d      = status_q;
    stat_o        = '0;
    mem_we_o      = 1'b0;
    mem_waddr_o   = word_of(j_q);
    mem_wdata_o   = mem_rdata_a_i | (WordW'(1) << j_q[5:1]);
    mem_raddr_a_o = word_of(NumW'(p_q));
    mem_raddr_b_o = word_of(NumW'(m_q));
    unique case (state_q)
      SIdle: begin
        if (q_valid_i) begin
          n_d     = q_number_i;
          clr_d   = '0;
          state_d = ctl_i.sieve_ready ? SQSet : SClr;
        end
      end
      SClr: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        mem_wdata_o = '0;
        clr_d       = clr_q + AddrW'(1);
        if (clr_q == last_word) begin
          i_d     = NumW'(3);
          sq_d    = NumW'(9);
          state_d = SSvTest;
        end
      end
      SSvTest: begin
        mem_raddr_a_o = word_of(i_q);
        if (sq_q > lim_ext) begin
          stat_o.built = 1'b1;
          state_d      = SQSet;
        end else begin
          state_d = SSvChk;
        end
      end
      SSvChk: begin
        if (mem_rdata_a_i[i_q[5:1]]) begin
          i_d     = i_q + NumW'(2);
          sq_d    = sq_q + (i_q << 2) + NumW'(4);
          state_d = SSvTest;
        end else begin
          j_d     = sq_q;
          state_d = SMkRd;
        end
      end
      SMkRd: begin
        mem_raddr_a_o = word_of(j_q);
        if (j_q >= lim_ext) begin
          i_d     = i_q + NumW'(2);
          sq_d    = sq_q + (i_q << 2) + NumW'(4);
          state_d = SSvTest;
        end else begin
          state_d = SMkWr;
        end
      end
      SMkWr: begin
        // set the bit of j, step to the next odd multiple
        mem_we_o = 1'b1;
        j_d      = j_q + (i_q << 1);
        state_d  = SMkRd;
      end
      SQSet: begin
        p_d = QryW'(3);
        m_d = n_q - QryW'(3);
        if (n_q[0] || n_q < QryW'(6) || LimW'(n_q) >= limit_i) begin
          small_d  = '0;
          large_d  = '0;
          status_d = StatusReject;
          state_d  = SDone;
        end else begin
          state_d = SQRd;
        end
      end
      SQRd: begin
        if (p_q > (n_q >> 1)) begin
          small_d  = '0;
          large_d  = '0;
          status_d = StatusReject;
          state_d  = SDone;
        end else begin
          state_d = SQChk;
        end
      end
      SQChk: begin
        if (!mem_rdata_a_i[p_q[5:1]] && !mem_rdata_b_i[m_q[5:1]]) begin
          small_d  = p_q;
          large_d  = m_q;
          status_d = StatusPair;
          state_d  = SDone;
        end else begin
          p_d     = p_q + QryW'(2);
          m_d     = m_q - QryW'(2);
          state_d = SQRd;
        end
      end
      SDone: begin
        // hold until the output register is free
        if (ctl_i.res_take) begin
          stat_o.res_load = 1'b1;
          state_d         = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    p_q      <= p_d;
    m_q      <= m_d;
    i_q      <= i_d;
    sq_q     <= sq_d;
    j_q      <= j_d;
    clr_q    <= clr_d;
    small_q  <= small_d;
    large_q  <= large_d;
    status_q <= status_d;
  end

  assign q_stall_o    = (state_q != SIdle);
  assign res_small_o  = small_q;
  assign res_large_o  = large_q;
  assign res_status_o = status_q;

endmodule

// File: rtl/goldbach_prime_pair_finder.sv
// Top level of the Goldbach prime pair finder: config port, sequencer, map, output register.
//
// Query channel: query_valid_i / query_stall_o carry one query number per item.
// Result channel: result_valid_o / result_stall_i carry smaller_prime_o,
// larger_prime_o and result_status_o (0 pair found, 1 rejected or no pair).
// The APB port holds sieve_limit at byte address 0; a write clamps the value
// to 8..MAX_RANGE and marks the map stale. pready is always high.
// The map is rebuilt at the first query after reset or after a limit write:
// a clearing pass over map words 0 to (limit-1)/64, then for each odd i with
// i*i <= limit a read and check of its map bit, and for each such i that is
// prime a read, then write back of one map word per odd multiple marked.
// The input stays stalled throughout the build.
// With the map built a query tries odd candidates in turn; each candidate
// costs one paired read of the map and one check. One query is in work at a time.
// The result sits in an output register; a new query is taken while it waits,
// and a finished search holds while that register is full and result_stall_i is high.
// Reset clears the control state and loads a limit of 1000000 (clamped).
module goldbach_prime_pair_finder import gpf_pkg::*; #(
  parameter int MAX_RANGE = 1048576
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             query_valid_i,
  output logic             query_stall_o,
  input  logic [QryW-1:0]  query_number_i,
  output logic             result_valid_o,
  input  logic             result_stall_i,
  output logic [QryW-1:0]  smaller_prime_o,
  output logic [QryW-1:0]  larger_prime_o,
  output logic             result_status_o
);

  localparam int MapWords = (MAX_RANGE + 63) / 64;
  localparam int AddrW    = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int LimRstC  = (LimitReset > MAX_RANGE) ? MAX_RANGE : LimitReset;
  localparam logic [LimW-1:0] LimRst = LimW'(LimRstC);

  logic [LimW-1:0]  limit_q, limit_d;
  logic             ready_q, ready_d;
  logic             out_valid_q, out_valid_d;
  logic [QryW-1:0]  out_small_q;
  logic [QryW-1:0]  out_large_q;
  logic             out_status_q;

  logic [LimW-1:0]  wr_value;
  logic [LimW-1:0]  wr_clamped;
  logic             cfg_wr;

  seq_ctl_t         ctl;
  seq_stat_t        stat;
  logic [QryW-1:0]  res_small;
  logic [QryW-1:0]  res_large;
  logic             res_status;

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [WordW-1:0] mem_wdata;
  logic [AddrW-1:0] mem_raddr_a;
  logic [AddrW-1:0] mem_raddr_b;
  logic [WordW-1:0] mem_rdata_a;
  logic [WordW-1:0] mem_rdata_b;

  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == RegSieveLimit);
  assign wr_value = pwdata[LimW-1:0];

  always_comb begin
    priority if (wr_value < LimitMin) begin
      wr_clamped = LimitMin;
    end else if (32'(wr_value) > 32'(MAX_RANGE)) begin
      wr_clamped = LimW'(MAX_RANGE);
    end else begin
      wr_clamped = wr_value;
    end
  end

  always_comb begin
    limit_d = limit_q;
    ready_d = ready_q;
    if (cfg_wr) begin
      limit_d = wr_clamped;
      ready_d = 1'b0;
    end else if (stat.built) begin
      ready_d = 1'b1;
    end
  end

  assign ctl.sieve_ready = ready_q;
  assign ctl.res_take    = !out_valid_q || !result_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (stat.res_load) begin
      out_valid_d = 1'b1;
    end else if (!result_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LimRst;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      limit_q     <= limit_d;
      ready_q     <= ready_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.res_load) begin
      out_small_q  <= res_small;
      out_large_q  <= res_large;
      out_status_q <= res_status;
    end
  end

  gpf_seq #(
    .AddrW (AddrW)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .limit_i       (limit_q),
    .ctl_i         (ctl),
    .stat_o        (stat),
    .q_valid_i     (query_valid_i),
    .q_stall_o     (query_stall_o),
    .q_number_i    (query_number_i),
    .res_small_o   (res_small),
    .res_large_o   (res_large),
    .res_status_o  (res_status),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_a_o (mem_raddr_a),
    .mem_raddr_b_o (mem_raddr_b),
    .mem_rdata_a_i (mem_rdata_a),
    .mem_rdata_b_i (mem_rdata_b)
  );

  gpf_map #(
    .Words (MapWords),
    .AddrW (AddrW)
  ) u_map (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

  assign prdata          = (paddr[2] == RegSieveLimit) ? 32'(limit_q) : '0;
  assign pready          = 1'b1;
  assign result_valid_o  = out_valid_q;
  assign smaller_prime_o = out_small_q;
  assign larger_prime_o  = out_large_q;
  assign result_status_o = out_status_q;

endmodule

// File: rtl/gpf_checker.sv
// Port-level checks of the Goldbach prime pair finder, bound to the top level.
module gpf_checker import gpf_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            query_valid_i,
  input logic            query_stall_o,
  input logic            result_valid_o,
  input logic            result_stall_i,
  input logic [QryW-1:0] smaller_prime_o,
  input logic [QryW-1:0] larger_prime_o,
  input logic            result_status_o
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_stall_i |=> result_valid_o)
    else $error("result dropped while stalled");

  // an accepted item keeps the block busy for at least the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_valid_i && !query_stall_o |=> query_stall_o)
    else $error("query taken while the previous one is in work");

  // a found pair is two odd numbers in order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_status_o == StatusPair) |->
      smaller_prime_o[0] && larger_prime_o[0] && (larger_prime_o >= smaller_prime_o)
      && (smaller_prime_o >= QryW'(3)))
    else $error("malformed prime pair");

  // a reject carries zero primes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_status_o == StatusReject) |->
      (smaller_prime_o == '0) && (larger_prime_o == '0))
    else $error("reject with non-zero primes");

endmodule

bind goldbach_prime_pair_finder gpf_checker u_gpf_checker (.*);
